FILE: rtl/core/dnave_pkg.sv
`default_nettype none
package dnave_pkg;

   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_COMMA     = 8'h2c;
   localparam logic [7:0] CHAR_PLUS      = 8'h2b;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LESS      = 8'h3c;
   localparam logic [7:0] CHAR_GREATER   = 8'h3e;
   localparam logic [7:0] CHAR_SEMI      = 8'h3b;
   localparam logic [7:0] CHAR_TILDE     = 8'd126;
   localparam logic [7:0] HEX_NUM_BASE   = 8'h30;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

   // Up to three output bytes for one input item; last_idx is the index of the final byte.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      last_idx;
   } group_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = HEX_NUM_BASE + {4'd0, v};
      end else begin
         r = HEX_ALPHA_BASE + {4'd0, v};
      end
      return r;
   endfunction

   function automatic logic is_special(input logic [7:0] b);
      return (b == CHAR_COMMA) || (b == CHAR_PLUS) || (b == CHAR_QUOTE) ||
             (b == CHAR_BACKSLASH) || (b == CHAR_LESS) || (b == CHAR_GREATER) ||
             (b == CHAR_SEMI);
   endfunction

   function automatic logic [2:0] lead_count(input logic [7:0] b);
      logic [2:0] r;
      if ((b & 8'he0) == 8'hc0) begin
         r = 3'd1;
      end else if ((b & 8'hf0) == 8'he0) begin
         r = 3'd2;
      end else if ((b & 8'hf8) == 8'hf0) begin
         r = 3'd3;
      end else if ((b & 8'hfc) == 8'hf8) begin
         r = 3'd4;
      end else begin
         r = 3'd5;
      end
      return r;
   endfunction

   // Byte below 0x80: hex escape for controls and DEL, backslash for specials.
   function automatic group_type ascii_group(input logic [7:0] b);
      group_type g;
      g.bytes    = {b, b, b};
      g.last_idx = 2'd0;
      if ((b < CHAR_SPACE) || (b > CHAR_TILDE)) begin
         g.bytes[0] = CHAR_BACKSLASH;
         g.bytes[1] = hex_digit(b[7:4]);
         g.bytes[2] = hex_digit(b[3:0]);
         g.last_idx = 2'd2;
      end else if (is_special(b)) begin
         g.bytes[0] = CHAR_BACKSLASH;
         g.bytes[1] = b;
         g.last_idx = 2'd1;
      end
      return g;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dn_attribute_value_escaper.sv
`default_nettype none
// Escapes one distinguished-name attribute value, one input item per raw byte, into
// string form, one output byte per result item; rsp_tlast marks the final byte produced
// by each input item. Each input item yields one to three output bytes and holds the result
// port until its last byte is taken: the one-byte-per-cycle result port sets the rate while
// rsp_tready is high. One item waits in an input register while the previous item's bytes
// drain; each passes the input register, then the serializer's group register, to the output.
module dn_attribute_value_escaper
   import dnave_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // data_byte
   input  wire logic [1:0] req_tuser,   // [0] kind, [1] first_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte
   output logic            rsp_tlast    // out_last
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;
   logic       in_kind_ff;
   logic       in_kind_in;
   logic       in_first_ff;
   logic       in_first_in;
   logic       in_last_ff;
   logic       in_last_in;
   logic       load_ready;
   logic       advance;
   group_type  group;

   assign advance    = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || load_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_kind_in  = in_kind_ff;
      in_first_in = in_first_ff;
      in_last_in  = in_last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_kind_in  = req_tuser[0];
         in_first_in = req_tuser[1];
         in_last_in  = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_kind_ff  <= in_kind_in;
      in_first_ff <= in_first_in;
      in_last_ff  <= in_last_in;
   end

   dnave_escape u_escape (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (in_byte_ff),
      .kind       (in_kind_ff),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .group      (group)
   );

   dnave_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_group (group),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/core/dnave_escape.sv
`default_nettype none
module dnave_escape
   import dnave_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] data_byte,
   input  wire logic       kind,
   input  wire logic       first_byte,
   input  wire logic       last_byte,
   output group_type       group
);

   logic [2:0] cont_ff;
   logic [2:0] cont_in;
   logic [2:0] cont_cur;
   logic [2:0] cont_nxt;

   always_comb begin
      cont_cur = first_byte ? 3'd0 : cont_ff;
      cont_nxt = cont_cur;
      group.bytes    = {data_byte, data_byte, data_byte};
      group.last_idx = 2'd0;
      if (first_byte && ((data_byte == CHAR_SPACE) || (data_byte == CHAR_HASH))) begin
         cont_nxt = 3'd0;
         group.bytes[0] = CHAR_BACKSLASH;
         group.last_idx = 2'd1;
      end else if (last_byte && (data_byte == CHAR_SPACE)) begin
         cont_nxt = 3'd0;
         group.bytes[0] = CHAR_BACKSLASH;
         group.last_idx = 2'd1;
      end else if (kind) begin
         // Latin-1: re-encode high bytes as two-byte UTF-8
         cont_nxt = 3'd0;
         if (data_byte[7]) begin
            group.bytes[0] = {6'b110000, data_byte[7:6]};
            group.bytes[1] = {2'b10, data_byte[5:0]};
            group.last_idx = 2'd1;
         end else begin
            group = ascii_group(data_byte);
         end
      end else if ((cont_cur != 3'd0) && (data_byte[7:6] == 2'b10)) begin
         cont_nxt = cont_cur - 3'd1;
      end else if (data_byte[7]) begin
         cont_nxt = lead_count(data_byte);
      end else begin
         cont_nxt = 3'd0;
         group = ascii_group(data_byte);
      end
      if (last_byte) begin
         cont_nxt = 3'd0;
      end
      cont_in = advance ? cont_nxt : cont_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff <= 3'd0;
      end else begin
         cont_ff <= cont_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/dnave_serializer.sv
`default_nettype none
module dnave_serializer
   import dnave_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load_valid,
   input  wire group_type  load_group,
   output logic            load_ready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte
   output logic            rsp_tlast    // out_last
);

   group_type  grp_ff;
   group_type  grp_in;
   logic       valid_ff;
   logic       valid_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       at_last;
   logic       load;

   assign at_last    = (idx_ff == grp_ff.last_idx);
   assign load_ready = !valid_ff || (rsp_tready && at_last);
   assign load       = load_valid && load_ready;

   always_comb begin
      grp_in   = grp_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         grp_in   = load_group;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp_tready) begin
         // advance within the group, drop it after the final byte
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_tdata = grp_ff.bytes[0];
         2'd1:    rsp_tdata = grp_ff.bytes[1];
         2'd2:    rsp_tdata = grp_ff.bytes[2];
         default: rsp_tdata = grp_ff.bytes[0];
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

endmodule
`default_nettype wire

FILE: tb/dn_escape_checker.sv
`timescale 1ns / 1ps
module dn_escape_checker
   import dnave_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // data_byte
   input  wire logic [1:0] req_tuser,   // [0] kind, [1] first_byte
   input  wire logic       req_tlast,   // last_byte
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // out_byte
   input  wire logic       rsp_tlast,   // out_last
   output int              mismatch_count,
   output int              bytes_owed,
   output int              bytes_checked
);

   typedef struct packed {
      logic [7:0] text;
      logic       tail;
   } esc_byte_type;

   typedef enum logic [1:0] {
      ESCAPED_EDGE,
      LATIN_PAIR,
      RAW_PASS,
      ASCII_TEXT
   } esc_path_type;

   esc_byte_type owed_text[$];
   esc_byte_type want;
   logic [2:0]   utf8_left;
   int           errors;
   int           checked;

   function automatic logic [7:0] hex_glyph(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return 8'h41 + 8'(v) - 8'd10;
   endfunction

   // Work out the escaped text for one input byte and queue it.
   task automatic predict_escape(input logic [7:0] b, input logic latin, input logic head,
                                 input logic tail);
      esc_path_type path;
      logic [7:0]   txt [3];
      int           n;
      int           i;
      if (head) utf8_left = '0;
      if ((head && (b == CHAR_SPACE || b == CHAR_HASH)) || (tail && b == CHAR_SPACE)) begin
         utf8_left = '0;
         path = ESCAPED_EDGE;
      end else if (latin) begin
         utf8_left = '0;
         path = b[7] ? LATIN_PAIR : ASCII_TEXT;
      end else if (utf8_left != 3'd0 && b[7:6] == 2'b10) begin
         utf8_left = utf8_left - 3'd1;
         path = RAW_PASS;
      end else if (b[7]) begin
         // new lead: count of ones after the top bit sets the tail length, up to four; else five
         casez (b)
            8'b110?????: utf8_left = 3'd1;
            8'b1110????: utf8_left = 3'd2;
            8'b11110???: utf8_left = 3'd3;
            8'b111110??: utf8_left = 3'd4;
            default:     utf8_left = 3'd5;
         endcase
         path = RAW_PASS;
      end else begin
         utf8_left = '0;
         path = ASCII_TEXT;
      end
      if (tail) utf8_left = '0;

      case (path)
         ESCAPED_EDGE: begin
            txt[0] = CHAR_BACKSLASH;
            txt[1] = b;
            n = 2;
         end
         LATIN_PAIR: begin
            txt[0] = {6'b110000, b[7:6]};
            txt[1] = {2'b10, b[5:0]};
            n = 2;
         end
         RAW_PASS: begin
            txt[0] = b;
            n = 1;
         end
         default: begin
            if (b < CHAR_SPACE || b > CHAR_TILDE) begin
               txt[0] = CHAR_BACKSLASH;
               txt[1] = hex_glyph(b[7:4]);
               txt[2] = hex_glyph(b[3:0]);
               n = 3;
            end else begin
               case (b)
                  CHAR_COMMA, CHAR_PLUS, CHAR_QUOTE, CHAR_BACKSLASH,
                  CHAR_LESS, CHAR_GREATER, CHAR_SEMI: begin
                     txt[0] = CHAR_BACKSLASH;
                     txt[1] = b;
                     n = 2;
                  end
                  default: begin
                     txt[0] = b;
                     n = 1;
                  end
               endcase
            end
         end
      endcase

      for (i = 0; i < n; i++) owed_text.push_back('{txt[i], i == n - 1});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         utf8_left = '0;
         owed_text.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (owed_text.size() == 0) begin
               errors++;
               if (errors <= 30)
                  $display("%0t: output byte %h last %b with nothing expected", $time,
                           rsp_tdata, rsp_tlast);
            end else begin
               want = owed_text.pop_front();
               if (rsp_tdata !== want.text) begin
                  errors++;
                  if (errors <= 30)
                     $display("%0t: out_byte expected %h actual %h", $time, want.text,
                              rsp_tdata);
               end
               if (rsp_tlast !== want.tail) begin
                  errors++;
                  if (errors <= 30)
                     $display("%0t: out_last expected %b actual %b", $time, want.tail,
                              rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_escape(req_tdata, req_tuser[0], req_tuser[1], req_tlast);
      end
      mismatch_count <= errors;
      bytes_owed     <= owed_text.size();
      bytes_checked  <= checked;
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import dnave_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DIRECTED    = 24;
   localparam int RANDOM_ITEMS = 306;
   localparam int LONG_HOLD   = 80;
   localparam logic [6:0][7:0] SPECIALS = {CHAR_SEMI, CHAR_GREATER, CHAR_LESS, CHAR_BACKSLASH,
                                           CHAR_QUOTE, CHAR_PLUS, CHAR_COMMA};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;   // data_byte
   logic [1:0] req_tuser = '0;   // [0] kind, [1] first_byte
   logic       req_tlast = 1'b0; // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // out_byte
   logic       rsp_tlast;        // out_last

   int   mismatch_count;
   int   bytes_owed;
   int   bytes_checked;
   int   items_sent = 0;
   int   values_sent = 0;
   int   cycle_count = 0;
   int   gap_odds = 4;
   logic long_hold_req = 1'b0;
   logic hold_asked = 1'b0;

   always #1 clock = ~clock;

   dn_attribute_value_escaper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   dn_escape_checker escape_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .bytes_owed     (bytes_owed),
      .bytes_checked  (bytes_checked)
   );

   task automatic offer_byte(input logic [7:0] b, input logic latin, input logic head,
                             input logic tail);
      int gap;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {head, latin};
      req_tlast  <= tail;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Build one attribute value, mostly well formed, and offer its bytes.
   task automatic send_random_value();
      logic [7:0] text[$];
      int         len;
      int         k;
      int         keep;
      int         i;
      logic       latin;
      logic       mixed;
      logic       noisy;
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      latin = 1'($urandom);
      mixed = ($urandom_range(0, 9) == 0);
      noisy = ($urandom_range(0, 11) == 0);
      while (text.size() < len) begin
         case ($urandom_range(0, 9))
            0: text.push_back(CHAR_SPACE);
            1: text.push_back(CHAR_HASH);
            2: text.push_back(SPECIALS[$urandom_range(0, 6)]);
            3: text.push_back(($urandom_range(0, 4) == 0) ? 8'h7f : 8'($urandom_range(0, 31)));
            4, 5: text.push_back(8'($urandom_range(32, 126)));
            6, 7, 8: begin
               k    = $urandom_range(1, 5);
               // now and then cut the sequence short
               keep = ($urandom_range(0, 5) == 0) ? $urandom_range(0, k - 1) : k;
               text.push_back(8'(8'hff << (7 - k)) | (8'($urandom) & 8'(8'hff >> (k + 2))));
               repeat (keep) text.push_back({2'b10, 6'($urandom)});
            end
            default: text.push_back(8'($urandom));
         endcase
      end
      for (i = 0; i < text.size(); i++) begin
         if (mixed) latin = 1'($urandom);
         if (noisy) offer_byte(text[i], latin, 1'($urandom), 1'($urandom));
         else offer_byte(text[i], latin, i == 0, i == text.size() - 1);
      end
      values_sent++;
   endtask

   initial begin : stimulus
      int i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // leading and trailing space / hash
      offer_byte(CHAR_SPACE, 1'b0, 1'b1, 1'b1);
      offer_byte(CHAR_HASH, 1'b0, 1'b1, 1'b0);
      offer_byte(CHAR_SPACE, 1'b0, 1'b0, 1'b0);
      offer_byte(CHAR_SPACE, 1'b0, 1'b0, 1'b1);
      for (i = 0; i < 7; i++) offer_byte(SPECIALS[i], 1'(i), i == 0, i == 6);
      // controls, DEL and the top printable
      offer_byte(8'h00, 1'b0, 1'b1, 1'b0);
      offer_byte(8'h1f, 1'b1, 1'b0, 1'b0);
      offer_byte(8'h7f, 1'b0, 1'b0, 1'b0);
      offer_byte(8'h7e, 1'b1, 1'b0, 1'b1);
      // Latin-1 high bytes
      offer_byte(8'h80, 1'b1, 1'b1, 1'b0);
      offer_byte(8'hff, 1'b1, 1'b0, 1'b1);
      // UTF-8: good pair, lone continuation, broken sequences, 0xFE, short at the end
      offer_byte(8'hc3, 1'b0, 1'b1, 1'b0);
      offer_byte(8'ha9, 1'b0, 1'b0, 1'b0);
      offer_byte(8'h80, 1'b0, 1'b0, 1'b0);
      offer_byte(8'he2, 1'b0, 1'b0, 1'b0);
      offer_byte(8'h41, 1'b0, 1'b0, 1'b0);
      offer_byte(8'hfe, 1'b0, 1'b0, 1'b0);
      offer_byte(8'hfc, 1'b0, 1'b0, 1'b1);

      while (items_sent < DIRECTED + RANDOM_ITEMS) begin
         if (!hold_asked && items_sent >= DIRECTED + 60) begin
            hold_asked    = 1'b1;
            long_hold_req = 1'b1;
         end
         if (items_sent >= DIRECTED + RANDOM_ITEMS - 40) begin
            gap_odds = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: gap_odds = 0;
               1: gap_odds = 2;
               2: gap_odds = 4;
               default: gap_odds = 10;
            endcase
         end
         send_random_value();
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (bytes_owed != 0);
      repeat (12) @(posedge clock);
      $display("covered %0d input bytes in %0d random values plus directed escapes,",
               items_sent, values_sent);
      $display("both encodings, broken and short UTF-8, a long output stall; %0d bytes checked",
               bytes_checked);
      if (mismatch_count == 0 && bytes_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Output side: random stalls, plus one long hold-off to back up the input.
   initial begin : receiver
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
                  bytes_owed);
         $display("status: fail");
         $finish;
      end
   end

endmodule

FILE: files.f
rtl/core/dnave_pkg.sv
rtl/core/dnave_escape.sv
rtl/core/dnave_serializer.sv
rtl/core/dn_attribute_value_escaper.sv
tb/dn_escape_checker.sv
tb/testbench.sv
